### rtl/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Command and status codes shared by the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_PUSH_LEFT  = 2'd0;
  localparam cmd_t CMD_PUSH_RIGHT = 2'd1;
  localparam cmd_t CMD_POP_LEFT   = 2'd2;
  localparam cmd_t CMD_POP_RIGHT  = 2'd3;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_EMPTY_POP = 2'd1;
  localparam status_t ST_FULL_PUSH = 2'd2;

  localparam int VALUE_W = 32;
  localparam int FILL_W  = 7;

endpackage
`default_nettype wire

### rtl/double_ended_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue kept in a circular entry RAM.
// ----------------------------------------------------------------------------
// Each input beat carries one command (push or pop at the left or right end)
// and yields exactly one output beat with the popped value, a status code,
// the fill count and empty/full flags. Pushes and refused commands load the
// output register directly; a successful pop first reads the entry RAM, whose
// read is registered. A new beat is taken once the previous result is in the
// output register and that register is free or being drained.
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_cmd,
  input  wire logic signed [31:0]  in_push_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       out_pop_value,
  output logic [1:0]               out_status,
  output logic [6:0]               out_fill_count,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CAP  = CW'(DEPTH);

  logic [AW-1:0] left_r, left_nxt, right_r, right_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [VALUE_W-1:0] pop_value_r;
  status_t            status_r, status_nxt;
  logic [FILL_W-1:0]  fill_r;
  logic               empty_r, full_r;

  logic               accept, full, empty;
  logic [AW-1:0]      lm1, lp1, rm1, rp1;
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [VALUE_W-1:0] rdata;
  logic [31:0]        count_ext;

  deq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_push_value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall = pend_r || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CAP);
  assign empty    = (count_r == '0);

  assign lm1 = (left_r == '0) ? LAST : left_r - 1'b1;
  assign lp1 = (left_r == LAST) ? '0 : left_r + 1'b1;
  assign rm1 = (right_r == '0) ? LAST : right_r - 1'b1;
  assign rp1 = (right_r == LAST) ? '0 : right_r + 1'b1;

  always_comb begin
    left_nxt   = left_r;
    right_nxt  = right_r;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = right_r;
    raddr      = left_r;
    pend_nxt   = 1'b0;
    if (accept) begin
      case (in_cmd)
        CMD_PUSH_LEFT: begin
          if (full) begin
            status_nxt = ST_FULL_PUSH;
          end else begin
            we        = 1'b1;
            waddr     = lm1;
            left_nxt  = lm1;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_PUSH_RIGHT: begin
          if (full) begin
            status_nxt = ST_FULL_PUSH;
          end else begin
            we        = 1'b1;
            waddr     = right_r;
            right_nxt = rp1;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_POP_LEFT: begin
          if (empty) begin
            status_nxt = ST_EMPTY_POP;
          end else begin
            re        = 1'b1;
            raddr     = left_r;
            left_nxt  = lp1;
            count_nxt = count_r - 1'b1;
            pend_nxt  = 1'b1;
          end
        end
        default: begin
          if (empty) begin
            status_nxt = ST_EMPTY_POP;
          end else begin
            re        = 1'b1;
            raddr     = rm1;
            right_nxt = rm1;
            count_nxt = count_r - 1'b1;
            pend_nxt  = 1'b1;
          end
        end
      endcase
    end
  end

  assign count_ext = 32'(count_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((accept && !pend_nxt) || pend_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      right_r     <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pop_value_r <= '0;
      status_r    <= status_nxt;
      fill_r      <= count_ext[FILL_W-1:0];
      empty_r     <= (count_nxt == '0);
      full_r      <= (count_nxt == CAP);
    end else if (pend_r) begin
      pop_value_r <= rdata;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pop_value  = pop_value_r;
  assign out_status     = status_r;
  assign out_fill_count = fill_r;
  assign out_is_empty   = empty_r;
  assign out_is_full    = full_r;

endmodule
`default_nettype wire

### rtl/deq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port RAM, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for double_ended_queue_unit.
// ----------------------------------------------------------------------------
// Command beats are queued by a stimulus process and sent by a clocked
// driver. A clocked monitor predicts every accepted command against a shadow
// deque and compares each output beat field by field, in order. The run
// covers empty and full refusals, index wrap at both ends and long output
// back-pressure, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import deq_pkg::*;

  localparam int DEPTH          = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] value;
  } cmd_beat_t;

  typedef struct {
    logic [31:0] pop_value;
    status_t     status;
    logic [6:0]  fill_count;
    logic        is_empty;
    logic        is_full;
  } deq_reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  cmd_t               in_cmd = CMD_PUSH_LEFT;
  logic signed [31:0] in_push_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_pop_value;
  logic [1:0]         out_status;
  logic [6:0]         out_fill_count;
  logic               out_is_empty;
  logic               out_is_full;

  double_ended_queue_unit #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_push_value(in_push_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pop_value(out_pop_value),
    .out_status(out_status),
    .out_fill_count(out_fill_count),
    .out_is_empty(out_is_empty),
    .out_is_full(out_is_full)
  );

  cmd_beat_t   cmd_backlog[$];
  deq_reply_t  deque_replies[$];
  logic [31:0] shadow_slots[DEPTH];
  int          shadow_left = 0;
  int          shadow_right = 0;
  int          shadow_held = 0;
  int          plan_held = 0;
  int          err_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int wrap_up(int i);
    return (i + 1 == DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int wrap_down(int i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  // Advance the shadow deque by one command and queue its reply.
  task automatic apply_command(cmd_t cmd, logic [31:0] value);
    deq_reply_t r;
    r.pop_value = '0;
    r.status    = ST_DONE;
    if (cmd == CMD_PUSH_LEFT || cmd == CMD_PUSH_RIGHT) begin
      if (shadow_held >= DEPTH) begin
        r.status = ST_FULL_PUSH;
      end else if (cmd == CMD_PUSH_LEFT) begin
        shadow_left = wrap_down(shadow_left);
        shadow_slots[shadow_left] = value;
        shadow_held++;
      end else begin
        shadow_slots[shadow_right] = value;
        shadow_right = wrap_up(shadow_right);
        shadow_held++;
      end
    end else begin
      if (shadow_held == 0) begin
        r.status = ST_EMPTY_POP;
      end else if (cmd == CMD_POP_LEFT) begin
        r.pop_value = shadow_slots[shadow_left];
        shadow_left = wrap_up(shadow_left);
        shadow_held--;
      end else begin
        shadow_right = wrap_down(shadow_right);
        r.pop_value = shadow_slots[shadow_right];
        shadow_held--;
      end
    end
    r.fill_count = shadow_held[6:0];
    r.is_empty   = (shadow_held == 0);
    r.is_full    = (shadow_held >= DEPTH);
    deque_replies.push_back(r);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Monitor: sample both channels, check replies, predict commands.
  always @(posedge clk) begin : monitor_proc
    deq_reply_t want;
    in_taken  = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (out_taken) begin
      if (deque_replies.size() == 0) begin
        err_count++;
        $display("%0t ns: unexpected output beat, expected none, actual status %0d",
                 $time, out_status);
      end else begin
        want = deque_replies.pop_front();
        check_field("pop_value", want.pop_value, out_pop_value);
        check_field("status", want.status, out_status);
        check_field("fill_count", want.fill_count, out_fill_count);
        check_field("is_empty", want.is_empty, out_is_empty);
        check_field("is_full", want.is_full, out_is_full);
      end
    end
    if (in_taken) begin
      apply_command(in_cmd, in_push_value);
    end
    if (in_taken || out_taken || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Driver: hold a stalled beat, otherwise offer the next one or idle.
  always @(negedge clk) begin : driver_proc
    cmd_beat_t nxt;
    logic      offer;
    offer = in_valid && !in_taken;
    if (rst_n && !offer && cmd_backlog.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      nxt = cmd_backlog.pop_front();
      in_cmd        <= nxt.cmd;
      in_push_value <= nxt.value;
      offer = 1'b1;
    end
    in_valid <= offer;
  end

  // Receiver: random stall, or a long hold-off when requested.
  always @(negedge clk) begin : receiver_proc
    if (hold_left == 0 && hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic plan(cmd_t cmd, logic [31:0] value);
    cmd_beat_t b;
    b.cmd   = cmd;
    b.value = value;
    cmd_backlog.push_back(b);
    if (cmd == CMD_PUSH_LEFT || cmd == CMD_PUSH_RIGHT) begin
      if (plan_held < DEPTH) plan_held++;
    end else if (plan_held > 0) begin
      plan_held--;
    end
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t random_push();
    return $urandom_range(1) ? CMD_PUSH_RIGHT : CMD_PUSH_LEFT;
  endfunction

  function automatic cmd_t random_pop();
    return $urandom_range(1) ? CMD_POP_RIGHT : CMD_POP_LEFT;
  endfunction

  // Fill to full, drain to empty, or mix, with a few refused commands.
  task automatic plan_random(int count);
    int start;
    int len;
    int push_pct;
    int kind;
    start = cmd_backlog.size();
    while (cmd_backlog.size() - start < count) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        while (plan_held < DEPTH) plan(random_push(), random_value());
        repeat ($urandom_range(3, 1)) plan(random_push(), random_value());
      end else if (kind < 4) begin
        while (plan_held > 0) plan(random_pop(), random_value());
        repeat ($urandom_range(3, 1)) plan(random_pop(), random_value());
      end else begin
        len      = $urandom_range(40, 10);
        push_pct = $urandom_range(80, 20);
        repeat (len) begin
          if ($urandom_range(99) < push_pct) plan(random_push(), random_value());
          else plan(random_pop(), random_value());
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() > 0 || in_valid || deque_replies.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin : stimulus_proc
    send_idle_pct = 18;
    recv_idle_pct = 53;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty pops, extreme values, wrap below slot zero
    plan(CMD_POP_LEFT, 32'hFFFF_FFFF);
    plan(CMD_POP_RIGHT, 32'h0000_0000);
    plan(CMD_PUSH_LEFT, 32'h8000_0000);
    plan(CMD_PUSH_RIGHT, 32'h7FFF_FFFF);
    plan(CMD_PUSH_LEFT, 32'hFFFF_FFFF);
    plan(CMD_PUSH_RIGHT, 32'h0000_0000);
    plan(CMD_POP_LEFT, 32'hAAAA_AAAA);
    plan(CMD_POP_RIGHT, 32'h5555_5555);
    plan(CMD_POP_LEFT, 32'h0000_0000);
    plan(CMD_POP_RIGHT, 32'hFFFF_FFFF);
    plan(CMD_POP_RIGHT, 32'h1234_5678);
    plan(CMD_PUSH_RIGHT, 32'hAAAA_AAAA);
    plan(CMD_PUSH_RIGHT, 32'h5555_5555);
    plan(CMD_PUSH_LEFT, 32'h0000_0001);
    plan(CMD_POP_RIGHT, 32'h0000_0000);
    plan(CMD_POP_LEFT, 32'h0000_0000);
    plan(CMD_POP_LEFT, 32'h0000_0000);
    plan(CMD_POP_LEFT, 32'h0000_0000);
    plan(CMD_POP_RIGHT, 32'h0000_0000);
    plan_random(70);
    wait_idle();

    send_idle_pct = 53;
    recv_idle_pct = 18;
    plan_random(90);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    plan_random(90);
    wait_idle();

    // hold the output long enough to back up the input
    hold_request = 300;
    repeat (40) plan(CMD_PUSH_RIGHT, random_value());
    repeat (40) plan(CMD_POP_LEFT, random_value());
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (deque_replies.size() != 0) begin
      err_count++;
      $display("%0t ns: missing output beats, expected %0d more, actual 0",
               $time, deque_replies.size());
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
